// ===== rtl/lgts_pkg.sv =====
`timescale 1ns / 1ps
package lgts_pkg;

  localparam int TOPICS = 64;
  localparam int VOCAB  = 4096;
  localparam int DOCS   = 1024;

  localparam int TOPIC_W   = $clog2(TOPICS);
  localparam int WT_DEPTH  = TOPICS * VOCAB;
  localparam int DT_DEPTH  = TOPICS * DOCS;
  localparam int WT_AW     = $clog2(WT_DEPTH);
  localparam int DT_AW     = $clog2(DT_DEPTH);
  localparam int CLR_DEPTH = (WT_DEPTH > DT_DEPTH) ? WT_DEPTH : DT_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  localparam int CNT_W    = 32;
  localparam int PRIOR_W  = 32;
  localparam int SMOOTH_W = 48;
  localparam int FRAC_W   = 24;
  localparam int RAND_W   = 32;
  localparam int WEIGHT_W = 48;
  localparam int OP_W     = CNT_W + FRAC_W + 1;
  localparam int PROD_W   = 2 * OP_W;
  localparam int SUM_W    = WEIGHT_W + TOPIC_W;
  localparam int BIT_W    = $clog2(WEIGHT_W);

  typedef enum logic [1:0] {
    CFG_DOC_PRIOR,
    CFG_WORD_PRIOR,
    CFG_TOTAL_SMOOTHING,
    CFG_TOPICS_IN_USE
  } cfg_idx_e;

  typedef enum logic {
    CMD_ASSIGN,
    CMD_RESAMPLE
  } cmd_e;

  typedef enum logic [2:0] {
    WU_IDLE,
    WU_MUL,
    WU_PRE,
    WU_DIV,
    WU_DONE
  } wu_state_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_W_RD,
    ST_W_WAIT,
    ST_W_CALC,
    ST_T_LO,
    ST_T_HI,
    ST_T_ADD,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_INC_RD,
    ST_INC_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic               clr;
    logic [CLR_AW-1:0]  clr_addr;
    logic [TOPIC_W-1:0] topic;
    logic [11:0]        word;
    logic [9:0]         doc;
    logic [CNT_W-1:0]   wc;
    logic [CNT_W-1:0]   dc;
    logic [CNT_W-1:0]   tc;
  } cs_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] wc;
    logic [CNT_W-1:0] dc;
    logic [CNT_W-1:0] tc;
  } cs_rsp_t;

endpackage

// ===== rtl/lgts_count_store.sv =====
`timescale 1ns / 1ps
module lgts_count_store (
  input  logic              clk_i,
  input  lgts_pkg::cs_req_t req_i,
  output lgts_pkg::cs_rsp_t rsp_o
);

  logic [lgts_pkg::CNT_W-1:0] wt_mem [lgts_pkg::WT_DEPTH];
  logic [lgts_pkg::CNT_W-1:0] dt_mem [lgts_pkg::DT_DEPTH];
  logic [lgts_pkg::CNT_W-1:0] tt_mem [lgts_pkg::TOPICS];
  logic [lgts_pkg::WT_AW-1:0] wt_addr;
  logic [lgts_pkg::DT_AW-1:0] dt_addr;
  lgts_pkg::cs_rsp_t          rsp_q;

  assign wt_addr = lgts_pkg::WT_AW'(req_i.topic) * lgts_pkg::WT_AW'(lgts_pkg::VOCAB)
                 + lgts_pkg::WT_AW'(req_i.word);
  assign dt_addr = lgts_pkg::DT_AW'(req_i.topic) * lgts_pkg::DT_AW'(lgts_pkg::DOCS)
                 + lgts_pkg::DT_AW'(req_i.doc);

  always_ff @(posedge clk_i) begin
    if (req_i.clr) begin
      if (32'(req_i.clr_addr) < lgts_pkg::WT_DEPTH) begin
        wt_mem[req_i.clr_addr[lgts_pkg::WT_AW-1:0]] <= '0;
      end
      if (32'(req_i.clr_addr) < lgts_pkg::DT_DEPTH) begin
        dt_mem[req_i.clr_addr[lgts_pkg::DT_AW-1:0]] <= '0;
      end
      if (32'(req_i.clr_addr) < lgts_pkg::TOPICS) begin
        tt_mem[req_i.clr_addr[lgts_pkg::TOPIC_W-1:0]] <= '0;
      end
    end else if (req_i.wr) begin
      wt_mem[wt_addr]     <= req_i.wc;
      dt_mem[dt_addr]     <= req_i.dc;
      tt_mem[req_i.topic] <= req_i.tc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rsp_q.wc <= wt_mem[wt_addr];
      rsp_q.dc <= dt_mem[dt_addr];
      rsp_q.tc <= tt_mem[req_i.topic];
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/lgts_weight_unit.sv =====
`timescale 1ns / 1ps
module lgts_weight_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lgts_pkg::CNT_W-1:0]    wc_i,
  input  logic [lgts_pkg::CNT_W-1:0]    dc_i,
  input  logic [lgts_pkg::CNT_W-1:0]    tc_i,
  input  logic [lgts_pkg::PRIOR_W-1:0]  alpha_i,
  input  logic [lgts_pkg::PRIOR_W-1:0]  beta_i,
  input  logic [lgts_pkg::SMOOTH_W-1:0] smooth_i,
  output logic                          done_o,
  output logic [lgts_pkg::WEIGHT_W-1:0] weight_o
);

  localparam int HI_W = lgts_pkg::PROD_W - lgts_pkg::WEIGHT_W;

  lgts_pkg::wu_state_e state_q, state_d;

  logic [lgts_pkg::OP_W-1:0]     a_q, b_q, c_q;
  logic [2:0]                    step_q;
  logic [63:0]                   pp_q;
  logic [6:0]                    sh_q;
  logic [lgts_pkg::PROD_W-1:0]   acc_q;
  logic [lgts_pkg::OP_W-1:0]     r_q;
  logic [lgts_pkg::WEIGHT_W-1:0] lo_q, q_q;
  logic [lgts_pkg::BIT_W-1:0]    bit_q;
  logic                          sat_q;

  logic [31:0]                   op_x, op_y;
  logic [6:0]                    op_sh;
  logic [HI_W-1:0]               acc_hi;
  logic [lgts_pkg::OP_W:0]       r_shift;
  logic                          r_ge;

  always_comb begin
    case (step_q)
      3'd0:    begin op_x = a_q[31:0];                op_y = b_q[31:0];                op_sh = 7'd0;  end
      3'd1:    begin op_x = a_q[31:0];                op_y = 32'(b_q[lgts_pkg::OP_W-1:32]); op_sh = 7'd32; end
      3'd2:    begin op_x = 32'(a_q[lgts_pkg::OP_W-1:32]); op_y = b_q[31:0];           op_sh = 7'd32; end
      3'd3:    begin op_x = 32'(a_q[lgts_pkg::OP_W-1:32]); op_y = 32'(b_q[lgts_pkg::OP_W-1:32]);
                     op_sh = 7'd64; end
      default: begin op_x = '0;                       op_y = '0;                       op_sh = 7'd0;  end
    endcase
  end

  assign acc_hi  = acc_q[lgts_pkg::PROD_W-1:lgts_pkg::WEIGHT_W];
  assign r_shift = {r_q, lo_q[lgts_pkg::WEIGHT_W-1]};
  assign r_ge    = r_shift >= {1'b0, c_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgts_pkg::WU_IDLE: if (start_i) state_d = lgts_pkg::WU_MUL;
      lgts_pkg::WU_MUL:  if (step_q == 3'd4) state_d = lgts_pkg::WU_PRE;
      lgts_pkg::WU_PRE:  state_d = (acc_hi >= HI_W'(c_q)) ? lgts_pkg::WU_DONE : lgts_pkg::WU_DIV;
      lgts_pkg::WU_DIV:  if (bit_q == lgts_pkg::BIT_W'(lgts_pkg::WEIGHT_W - 1)) begin
        state_d = lgts_pkg::WU_DONE;
      end
      lgts_pkg::WU_DONE: state_d = lgts_pkg::WU_IDLE;
      default:           state_d = lgts_pkg::WU_IDLE;
    endcase
  end

  always_comb begin
    done_o   = (state_q == lgts_pkg::WU_DONE);
    weight_o = sat_q ? '1 : q_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgts_pkg::WU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lgts_pkg::WU_IDLE: begin
        a_q    <= (lgts_pkg::OP_W'(wc_i) << lgts_pkg::FRAC_W) + lgts_pkg::OP_W'(beta_i);
        b_q    <= (lgts_pkg::OP_W'(dc_i) << lgts_pkg::FRAC_W) + lgts_pkg::OP_W'(alpha_i);
        c_q    <= (lgts_pkg::OP_W'(tc_i) << lgts_pkg::FRAC_W) + lgts_pkg::OP_W'(smooth_i);
        step_q <= '0;
        acc_q  <= '0;
      end
      lgts_pkg::WU_MUL: begin
        pp_q   <= op_x * op_y;
        sh_q   <= op_sh;
        step_q <= step_q + 3'd1;
        if (step_q != 3'd0) begin
          acc_q <= acc_q + (lgts_pkg::PROD_W'(pp_q) << sh_q);
        end
      end
      lgts_pkg::WU_PRE: begin
        sat_q <= acc_hi >= HI_W'(c_q);
        r_q   <= acc_hi[lgts_pkg::OP_W-1:0];
        lo_q  <= acc_q[lgts_pkg::WEIGHT_W-1:0];
        q_q   <= '0;
        bit_q <= '0;
      end
      lgts_pkg::WU_DIV: begin
        r_q   <= r_ge ? lgts_pkg::OP_W'(r_shift - {1'b0, c_q})
                      : r_shift[lgts_pkg::OP_W-1:0];
        lo_q  <= {lo_q[lgts_pkg::WEIGHT_W-2:0], 1'b0};
        q_q   <= {q_q[lgts_pkg::WEIGHT_W-2:0], r_ge};
        bit_q <= bit_q + 1'b1;
      end
      lgts_pkg::WU_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/lda_gibbs_topic_sampler.sv =====
`timescale 1ns / 1ps
// Channel   Signals                                            Direction
// input     in_valid_i, in_stall_o, cmd_i, word_index_i,       in
//           doc_index_i, old_topic_i, random_fraction_i
// result    out_valid_o, out_stall_i, new_topic_o              out
// config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i  in
//
// Assign item: count read, write back, result.
// Resample item: decrement, a weight per topic for the K topics in use, draw, then as assign;
// per topic the shared weight unit takes 4 partial products and up to 48 divide steps.
// After reset the count memories are cleared one entry a cycle, all TOPICS*VOCAB entries,
// while no item is taken; config writes are taken at all times.
// A stalled result holds; the finished item waits at its end and no next item is taken meanwhile.
module lda_gibbs_topic_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [11:0] word_index_i,
  input  logic [9:0]  doc_index_i,
  input  logic [5:0]  old_topic_i,
  input  logic [31:0] random_fraction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  new_topic_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  lgts_pkg::state_e state_q, state_d;

  logic [lgts_pkg::CLR_AW-1:0]   clr_cnt_q;
  logic [lgts_pkg::PRIOR_W-1:0]  doc_prior_q, word_prior_q;
  logic [lgts_pkg::SMOOTH_W-1:0] smooth_q;
  logic [6:0]                    tiu_q;

  lgts_pkg::cmd_e                cmd_q;
  logic [11:0]                   word_q;
  logic [9:0]                    doc_q;
  logic [lgts_pkg::RAND_W-1:0]   frac_q;
  logic [lgts_pkg::TOPIC_W-1:0]  t_q, topic_q, last_topic;
  logic [lgts_pkg::SUM_W-1:0]    sum_q, mhi_q, target_q, cum_q, cum_nxt;
  logic [63:0]                   mlo_q;
  logic [lgts_pkg::WEIGHT_W-1:0] wt_mem [lgts_pkg::TOPICS];
  logic [lgts_pkg::WEIGHT_W-1:0] wt_rd_q;
  logic                          out_valid_q;
  logic [5:0]                    out_topic_q;

  logic                          accept, in_range, load, walk_hit, t_last;
  lgts_pkg::cs_req_t             cs_req;
  lgts_pkg::cs_rsp_t             cs_rsp;
  logic                          wu_start, wu_done;
  logic [lgts_pkg::WEIGHT_W-1:0] wu_weight;

  lgts_count_store u_store (
    .clk_i (clk_i),
    .req_i (cs_req),
    .rsp_o (cs_rsp)
  );

  lgts_weight_unit u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wu_start),
    .wc_i     (cs_rsp.wc),
    .dc_i     (cs_rsp.dc),
    .tc_i     (cs_rsp.tc),
    .alpha_i  (doc_prior_q),
    .beta_i   (word_prior_q),
    .smooth_i (smooth_q),
    .done_o   (wu_done),
    .weight_o (wu_weight)
  );

  assign in_stall_o  = (state_q != lgts_pkg::ST_IDLE);
  assign accept      = in_valid_i && (state_q == lgts_pkg::ST_IDLE);
  assign in_range    = (32'(word_index_i) < lgts_pkg::VOCAB) && (32'(doc_index_i) < lgts_pkg::DOCS)
                    && (32'(old_topic_i) < lgts_pkg::TOPICS);
  assign load        = (state_q == lgts_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign new_topic_o = out_topic_q;

  always_comb begin
    if (tiu_q == 7'd0) begin
      last_topic = '0;
    end else if (32'(tiu_q) > lgts_pkg::TOPICS) begin
      last_topic = lgts_pkg::TOPIC_W'(lgts_pkg::TOPICS - 1);
    end else begin
      last_topic = lgts_pkg::TOPIC_W'(tiu_q - 7'd1);
    end
  end

  assign t_last   = (t_q == last_topic);
  assign cum_nxt  = cum_q + lgts_pkg::SUM_W'(wt_rd_q);
  assign walk_hit = cum_nxt >= target_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgts_pkg::ST_CLEAR: begin
        if (32'(clr_cnt_q) == lgts_pkg::CLR_DEPTH - 1) state_d = lgts_pkg::ST_IDLE;
      end
      lgts_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_range) state_d = lgts_pkg::ST_DONE;
          else if (cmd_i == lgts_pkg::CMD_ASSIGN) state_d = lgts_pkg::ST_INC_RD;
          else state_d = lgts_pkg::ST_DEC_RD;
        end
      end
      lgts_pkg::ST_DEC_RD:  state_d = lgts_pkg::ST_DEC_WR;
      lgts_pkg::ST_DEC_WR:  state_d = lgts_pkg::ST_W_RD;
      lgts_pkg::ST_W_RD:    state_d = lgts_pkg::ST_W_WAIT;
      lgts_pkg::ST_W_WAIT:  state_d = lgts_pkg::ST_W_CALC;
      lgts_pkg::ST_W_CALC: begin
        if (wu_done) state_d = t_last ? lgts_pkg::ST_T_LO : lgts_pkg::ST_W_RD;
      end
      lgts_pkg::ST_T_LO:    state_d = lgts_pkg::ST_T_HI;
      lgts_pkg::ST_T_HI:    state_d = lgts_pkg::ST_T_ADD;
      lgts_pkg::ST_T_ADD:   state_d = lgts_pkg::ST_WALK_RD;
      lgts_pkg::ST_WALK_RD: state_d = lgts_pkg::ST_WALK_CHK;
      lgts_pkg::ST_WALK_CHK: begin
        state_d = (walk_hit || t_last) ? lgts_pkg::ST_INC_RD : lgts_pkg::ST_WALK_RD;
      end
      lgts_pkg::ST_INC_RD:  state_d = lgts_pkg::ST_INC_WR;
      lgts_pkg::ST_INC_WR:  state_d = lgts_pkg::ST_DONE;
      lgts_pkg::ST_DONE:    if (load) state_d = lgts_pkg::ST_IDLE;
      default:              state_d = lgts_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cs_req          = '0;
    cs_req.clr_addr = clr_cnt_q;
    cs_req.topic    = topic_q;
    cs_req.word     = word_q;
    cs_req.doc      = doc_q;
    wu_start        = 1'b0;
    unique case (state_q)
      lgts_pkg::ST_CLEAR:  cs_req.clr = 1'b1;
      lgts_pkg::ST_DEC_RD,
      lgts_pkg::ST_INC_RD: cs_req.rd = 1'b1;
      lgts_pkg::ST_W_RD: begin
        cs_req.rd    = 1'b1;
        cs_req.topic = t_q;
      end
      lgts_pkg::ST_DEC_WR: begin
        cs_req.wr = 1'b1;
        cs_req.wc = (cs_rsp.wc == '0) ? '0 : cs_rsp.wc - 1'b1;
        cs_req.dc = (cs_rsp.dc == '0) ? '0 : cs_rsp.dc - 1'b1;
        cs_req.tc = (cs_rsp.tc == '0) ? '0 : cs_rsp.tc - 1'b1;
      end
      lgts_pkg::ST_INC_WR: begin
        cs_req.wr = 1'b1;
        cs_req.wc = (cs_rsp.wc == '1) ? cs_rsp.wc : cs_rsp.wc + 1'b1;
        cs_req.dc = (cs_rsp.dc == '1) ? cs_rsp.dc : cs_rsp.dc + 1'b1;
        cs_req.tc = (cs_rsp.tc == '1) ? cs_rsp.tc : cs_rsp.tc + 1'b1;
      end
      lgts_pkg::ST_W_WAIT: wu_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lgts_pkg::ST_CLEAR;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      doc_prior_q  <= 32'd1677722;
      word_prior_q <= 32'd184549;
      smooth_q     <= 48'd16777216;
      tiu_q        <= 7'd64;
    end else begin
      state_q <= state_d;
      if (state_q == lgts_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (lgts_pkg::cfg_idx_e'(cfg_index_i))
          lgts_pkg::CFG_DOC_PRIOR:       doc_prior_q  <= cfg_data_i[31:0];
          lgts_pkg::CFG_WORD_PRIOR:      word_prior_q <= cfg_data_i[31:0];
          lgts_pkg::CFG_TOTAL_SMOOTHING: smooth_q     <= cfg_data_i;
          lgts_pkg::CFG_TOPICS_IN_USE:   tiu_q        <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lgts_pkg::ST_W_CALC && wu_done) wt_mem[t_q] <= wu_weight;
    if (state_q == lgts_pkg::ST_WALK_RD) wt_rd_q <= wt_mem[t_q];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lgts_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_q   <= lgts_pkg::cmd_e'(cmd_i);
          word_q  <= word_index_i;
          doc_q   <= doc_index_i;
          frac_q  <= random_fraction_i;
          topic_q <= lgts_pkg::TOPIC_W'(old_topic_i);
        end
      end
      lgts_pkg::ST_DEC_WR: begin
        t_q   <= '0;
        sum_q <= '0;
      end
      lgts_pkg::ST_W_CALC: begin
        if (wu_done) begin
          sum_q <= sum_q + lgts_pkg::SUM_W'(wu_weight);
          if (!t_last) t_q <= t_q + 1'b1;
        end
      end
      lgts_pkg::ST_T_LO: mlo_q <= sum_q[31:0] * frac_q;
      lgts_pkg::ST_T_HI: mhi_q <= sum_q[lgts_pkg::SUM_W-1:32] * frac_q;
      lgts_pkg::ST_T_ADD: begin
        target_q <= lgts_pkg::SUM_W'(mhi_q + lgts_pkg::SUM_W'(mlo_q[63:32]));
        t_q      <= '0;
        cum_q    <= '0;
      end
      lgts_pkg::ST_WALK_CHK: begin
        cum_q <= cum_nxt;
        if (walk_hit || t_last) topic_q <= t_q;
        else t_q <= t_q + 1'b1;
      end
      lgts_pkg::ST_DONE: begin
        if (load) out_topic_q <= 6'(topic_q);
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lgts_pkg::ST_CLEAR |-> in_stall_o)
    else $error("item taken during clearing pass");
  a_wu_done_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wu_done |-> state_q == lgts_pkg::ST_W_CALC)
    else $error("weight done outside weight pass");
  a_wait_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lgts_pkg::ST_W_WAIT |-> $past(state_q) == lgts_pkg::ST_W_RD)
    else $error("weight unit started without count read");
  a_drawn_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lgts_pkg::ST_INC_WR && cmd_q == lgts_pkg::CMD_RESAMPLE
      |-> topic_q <= last_topic)
    else $error("drawn topic beyond topics in use");
`endif

endmodule
